[rtl/core/wce_pkg.sv]
// ----------------------------------------------------------------------------
// wce_pkg
// Shared constants and controller/datapath interface types for the weak
// composition enumerator.
// ----------------------------------------------------------------------------
package wce_pkg;

    localparam int MAX_PARTS    = 16;
    localparam int SUM_WIDTH    = 8;

    // part position index and a count that can hold MAX_PARTS itself
    localparam int IDX_W        = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
    localparam int CNT_W        = $clog2(MAX_PARTS + 1);

    localparam int NUM_PARTS_W  = 5;
    localparam int TOTAL_SUM_W  = 8;
    localparam int PART_VALUE_W = 8;
    localparam int PART_INDEX_W = 4;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 8;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_NUM_PARTS = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_TOTAL_SUM = CFG_INDEX_W'(1);

    typedef logic [SUM_WIDTH-1:0] part_t;

    // controller -> datapath
    typedef struct packed {
        logic rewind;     // load first vector
        logic advance;    // step to next vector using scan results
        logic load_part;  // move part[cnt] into the output register
        logic load_exh;   // move an exhausted result into the output register
    } wce_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic slot_free;  // output register empty or being taken
        logic last_idx;   // counter sits on the final part
        logic found;      // a nonzero part exists at positions 1..n-1
    } wce_status_t;

endpackage

[rtl/core/wce_datapath.sv]
// ----------------------------------------------------------------------------
// wce_datapath
// Part registers, configuration registers, emission counter, running scan for
// the rightmost nonzero part and the output register.
// ----------------------------------------------------------------------------
module wce_datapath
    import wce_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  wce_cmd_t                cmd,
    output wce_status_t             status,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [PART_VALUE_W-1:0] part_value,
    output logic [PART_INDEX_W-1:0] part_index,
    output logic                    last_part,
    output logic                    exhausted
);

    logic [NUM_PARTS_W-1:0]  num_parts_reg;
    logic [TOTAL_SUM_W-1:0]  total_sum_reg;
    part_t                   parts_reg [MAX_PARTS];
    part_t                   parts_next [MAX_PARTS];
    logic [IDX_W-1:0]        cnt_reg;
    logic [CNT_W-1:0]        eff_n;
    logic [CNT_W-1:0]        eff_n_m1;
    part_t                   rd_part;

    // scan state, gathered while a vector is emitted
    logic                    found_reg;
    logic [IDX_W-1:0]        k_reg;
    part_t                   rest_reg;
    part_t                   left_reg;
    part_t                   prev_reg;

    logic                    out_valid_reg;
    logic [PART_VALUE_W-1:0] value_reg;
    logic [PART_INDEX_W-1:0] index_reg;
    logic                    last_reg;
    logic                    exh_reg;
    logic                    load;

    always_comb
    begin
        if (num_parts_reg == '0)
            eff_n = CNT_W'(1);
        else if (int'(num_parts_reg) > MAX_PARTS)
            eff_n = CNT_W'(MAX_PARTS);
        else
            eff_n = CNT_W'(num_parts_reg);
    end

    assign eff_n_m1 = eff_n - CNT_W'(1);
    assign rd_part  = parts_reg[cnt_reg];
    assign load     = cmd.load_part | cmd.load_exh;

    assign status.slot_free = ~out_valid_reg | out_ready;
    assign status.last_idx  = (CNT_W'(cnt_reg) == eff_n_m1);
    assign status.found     = found_reg;

    // next vector: rewind or advance, one independent update per part
    always_comb
    begin
        for (int j = 0; j < MAX_PARTS; j++)
        begin
            parts_next[j] = parts_reg[j];
            if (cmd.rewind)
            begin
                if (CNT_W'(j) == eff_n_m1)
                    parts_next[j] = SUM_WIDTH'(total_sum_reg);
                else
                    parts_next[j] = '0;
            end
            else if (cmd.advance)
            begin
                if (CNT_W'(j + 1) == CNT_W'(k_reg))
                    parts_next[j] = left_reg + part_t'(1);
                if ((CNT_W'(j) >= CNT_W'(k_reg)) && (CNT_W'(j) < eff_n))
                    parts_next[j] = '0;
                if (CNT_W'(j) == eff_n_m1)
                    parts_next[j] = rest_reg - part_t'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_parts_reg <= NUM_PARTS_W'(3);
            total_sum_reg <= TOTAL_SUM_W'(2);
            for (int j = 0; j < MAX_PARTS; j++)
                parts_reg[j] <= '0;
            cnt_reg       <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == REG_NUM_PARTS))
                num_parts_reg <= NUM_PARTS_W'(cfg_data);
            if (cfg_we && (cfg_index == REG_TOTAL_SUM))
                total_sum_reg <= TOTAL_SUM_W'(cfg_data);

            for (int j = 0; j < MAX_PARTS; j++)
                parts_reg[j] <= parts_next[j];

            if (cmd.load_part)
            begin
                if (status.last_idx)
                    cnt_reg <= '0;
                else
                    cnt_reg <= cnt_reg + IDX_W'(1);
                if (cnt_reg == '0)
                    found_reg <= 1'b0;
                else if (rd_part != '0)
                    found_reg <= 1'b1;
            end

            if (load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // scan payload and output payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.load_part)
        begin
            prev_reg <= rd_part;
            if ((cnt_reg != '0) && (rd_part != '0))
            begin
                k_reg    <= cnt_reg;
                rest_reg <= rd_part;
                left_reg <= prev_reg;
            end
            value_reg <= PART_VALUE_W'(rd_part);
            index_reg <= PART_INDEX_W'(cnt_reg);
            last_reg  <= status.last_idx;
            exh_reg   <= 1'b0;
        end
        else if (cmd.load_exh)
        begin
            value_reg <= '0;
            index_reg <= '0;
            last_reg  <= 1'b1;
            exh_reg   <= 1'b1;
        end
    end

    assign out_valid  = out_valid_reg;
    assign part_value = value_reg;
    assign part_index = index_reg;
    assign last_part  = last_reg;
    assign exhausted  = exh_reg;

endmodule

[rtl/core/wce_ctrl.sv]
// ----------------------------------------------------------------------------
// wce_ctrl
// Request sequencer: decides rewind, advance or exhausted, and paces the
// emission of parts into the output register.
// ----------------------------------------------------------------------------
module wce_ctrl
    import wce_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        restart,
    input  logic        cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  wce_status_t status,
    output wce_cmd_t    cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_UPDATE = 2'd1;
    localparam logic [1:0] S_EMIT   = 2'd2;
    localparam logic [1:0] S_EXH    = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       started_reg, started_next;
    logic       done_reg, done_next;
    logic       adv_reg, adv_next;     // 1: advance, 0: rewind
    logic       accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid & in_ready;

    always_comb
    begin
        state_next   = state_reg;
        started_next = started_reg;
        done_next    = done_reg;
        adv_next     = adv_reg;
        cmd          = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (restart || !started_reg)
                    begin
                        started_next = 1'b1;
                        done_next    = 1'b0;
                        adv_next     = 1'b0;
                        state_next   = S_UPDATE;
                    end
                    else if (done_reg)
                        state_next = S_EXH;
                    else if (!status.found)
                    begin
                        done_next  = 1'b1;
                        state_next = S_EXH;
                    end
                    else
                    begin
                        adv_next   = 1'b1;
                        state_next = S_UPDATE;
                    end
                end
            end
            S_UPDATE:
            begin
                cmd.rewind  = ~adv_reg;
                cmd.advance = adv_reg;
                state_next  = S_EMIT;
            end
            S_EMIT:
            begin
                if (status.slot_free)
                begin
                    cmd.load_part = 1'b1;
                    if (status.last_idx)
                        state_next = S_IDLE;
                end
            end
            S_EXH:
            begin
                if (status.slot_free)
                begin
                    cmd.load_exh = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // a register write rewinds the enumeration
        if (cfg_we && ((cfg_index == REG_NUM_PARTS) || (cfg_index == REG_TOTAL_SUM)))
        begin
            started_next = 1'b0;
            done_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            started_reg <= 1'b0;
            done_reg    <= 1'b0;
            adv_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            started_reg <= started_next;
            done_reg    <= done_next;
            adv_reg     <= adv_next;
        end
    end

endmodule

[rtl/core/weak_composition_enumerator.sv]
// ----------------------------------------------------------------------------
// weak_composition_enumerator
// Walks all vectors of num_parts non-negative parts adding up to total_sum,
// in ascending lexicographic order, one vector per request.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid/in_ready, restart): each accepted request asks
//   for the next vector; restart=1 rewinds to (0,...,0,total_sum) first.
//   Result channel (out_valid/out_ready): a vector comes out as n results,
//   part 0 first, last_part set on the final one. Once the walk is over a
//   request returns a single result with exhausted set and zero parts.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 is
//   num_parts, index 1 is total_sum; either write rewinds. Always ready;
//   write only while no request is in flight.
// Timing:
//   A request is taken in idle, updates the part registers in S_UPDATE,
//   then issues one part per cycle from S_EMIT while the output slot is
//   free; an exhausted request goes from idle to S_EXH. The rate is set
//   by the single read port of the part register file. The first result
//   is loaded from S_EMIT, an exhausted result from S_EXH.
// Stall: the output register holds a result until taken; emission pauses
//   while out_ready is low. The next request is accepted while the last
//   result of the previous one still waits.
// Reset: num_parts=3, total_sum=2, the first request yields the first vector.
// ----------------------------------------------------------------------------
module weak_composition_enumerator
    import wce_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    restart,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [PART_VALUE_W-1:0] part_value,
    output logic [PART_INDEX_W-1:0] part_index,
    output logic                    last_part,
    output logic                    exhausted,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

    wce_cmd_t    cmd;
    wce_status_t status;
    logic        cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid & cfg_ready;

    // sequencer: started/done flags and request pacing
    wce_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .restart   (restart),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .status    (status),
        .cmd       (cmd)
    );

    // parts, config registers, scan and output register
    wce_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd        (cmd),
        .status     (status),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .part_value (part_value),
        .part_index (part_index),
        .last_part  (last_part),
        .exhausted  (exhausted)
    );

    // an exhausted result is a lone, zeroed, final result
    a_exh_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && exhausted |-> last_part && part_value == '0 && part_index == '0)
        else $error("exhausted result malformed");

    // parts of a vector follow each other without gaps
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_part |=> out_valid)
        else $error("gap inside a vector");

    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_part |=>
            part_index == PART_INDEX_W'($past(part_index) + 1'b1))
        else $error("part index did not step");

    // no new request while a vector is still going out
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_part |-> !in_ready)
        else $error("request taken mid-vector");

endmodule

[bench/wce_scoreboard.sv]
// ----------------------------------------------------------------------------
// wce_bench_pkg
// Behavioural predictor and result checker for the weak composition
// enumerator: tracks the walk state, expands each request into its parts.
// ----------------------------------------------------------------------------
package wce_bench_pkg;

    import wce_pkg::*;

    typedef struct {
        logic [PART_VALUE_W-1:0] value;
        logic [PART_INDEX_W-1:0] index;
        logic                    last;
        logic                    exh;
    } part_result_t;

    class composition_scoreboard;

        logic [NUM_PARTS_W-1:0] num_parts;
        logic [TOTAL_SUM_W-1:0] total_sum;
        part_t                  parts [MAX_PARTS];
        bit                     walking;    // first vector already issued
        bit                     finished;   // walk has run out
        part_result_t           expected_parts [$];
        int                     mismatches;

        function new();
            num_parts  = NUM_PARTS_W'(3);
            total_sum  = TOTAL_SUM_W'(2);
            foreach (parts[i])
                parts[i] = '0;
            walking    = 1'b0;
            finished   = 1'b0;
            mismatches = 0;
        endfunction

        // either register rewinds the walk; spare indexes are ignored
        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_NUM_PARTS)
            begin
                num_parts = data[NUM_PARTS_W-1:0];
                walking   = 1'b0;
                finished  = 1'b0;
            end
            else if (idx == REG_TOTAL_SUM)
            begin
                total_sum = data[TOTAL_SUM_W-1:0];
                walking   = 1'b0;
                finished  = 1'b0;
            end
        endfunction

        function void push_exhausted();
            part_result_t r;
            r.value = '0;
            r.index = '0;
            r.last  = 1'b1;
            r.exh   = 1'b1;
            expected_parts.push_back(r);
        endfunction

        function void push_vector(int n);
            part_result_t r;
            for (int i = 0; i < n; i++)
            begin
                r.value = parts[i];
                r.index = PART_INDEX_W'(i);
                r.last  = (i == n - 1);
                r.exh   = 1'b0;
                expected_parts.push_back(r);
            end
        endfunction

        // next vector in lexicographic order, or the exhausted marker
        function void note_request(logic restart);
            int    n;
            int    k;
            part_t rest;
            n = (num_parts == 0) ? 1 : ((num_parts > MAX_PARTS) ? MAX_PARTS : int'(num_parts));
            if (restart)
            begin
                walking  = 1'b0;
                finished = 1'b0;
            end
            if (finished)
            begin
                push_exhausted();
                return;
            end
            if (!walking)
            begin
                foreach (parts[i])
                    parts[i] = '0;
                parts[n-1] = part_t'(total_sum);
                walking    = 1'b1;
                push_vector(n);
                return;
            end
            k = 0;
            for (int i = 1; i < n; i++)
                if (parts[i] != '0)
                    k = i;
            if (k == 0)
            begin
                finished = 1'b1;
                push_exhausted();
                return;
            end
            rest       = parts[k];
            parts[k-1] = parts[k-1] + 1'b1;
            for (int i = k; i < n; i++)
                parts[i] = '0;
            parts[n-1] = rest - 1'b1;
            push_vector(n);
        endfunction

        task report_mismatch(string what);
            mismatches++;
            if (mismatches <= 50)
                $display("MISMATCH @%0t: %s", $realtime, what);
        endtask

        task check_part(part_result_t got);
            part_result_t want;
            if (expected_parts.size() == 0)
            begin
                report_mismatch($sformatf("result with nothing pending: index %0d value %0d",
                                          got.index, got.value));
                return;
            end
            want = expected_parts.pop_front();
            if (got.value !== want.value)
                report_mismatch($sformatf("part_value got %0d want %0d (part %0d)",
                                          got.value, want.value, want.index));
            if (got.index !== want.index)
                report_mismatch($sformatf("part_index got %0d want %0d", got.index, want.index));
            if (got.last !== want.last)
                report_mismatch($sformatf("last_part got %b want %b (part %0d)",
                                          got.last, want.last, want.index));
            if (got.exh !== want.exh)
                report_mismatch($sformatf("exhausted got %b want %b", got.exh, want.exh));
        endtask

    endclass

endpackage

[bench/weak_composition_enumerator_test.sv]
// ----------------------------------------------------------------------------
// weak_composition_enumerator_test
// Drives requests and register writes into the enumerator, predicts every
// part of every vector and checks each result in order under random idling.
// ----------------------------------------------------------------------------
module weak_composition_enumerator_test;

    timeunit 1ns;
    timeprecision 1ps;

    import wce_pkg::*;
    import wce_bench_pkg::*;

    // a request holds the block while its parts go out; allow margin
    localparam int DRAIN_CYCLES    = MAX_PARTS + 6;
    localparam int STALL_LIMIT     = 4000;
    localparam int TARGET_REQUESTS = 380;
    localparam int HOLD_OFF_CYCLES = 250;
    localparam int RESTART_PCT     = 6;

    // indexes past the two real registers: writes must be ignored
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = CFG_INDEX_W'(3);

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    in_valid  = 1'b0;
    logic                    in_ready;
    logic                    restart   = 1'b0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic [PART_VALUE_W-1:0] part_value;
    logic [PART_INDEX_W-1:0] part_index;
    logic                    last_part;
    logic                    exhausted;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_INDEX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data  = '0;

    composition_scoreboard walk_board = new();

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_off_left  = 0;
    int requests_sent  = 0;
    int quiet_cycles   = 0;

    weak_composition_enumerator i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .restart    (restart),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .part_value (part_value),
        .part_index (part_index),
        .last_part  (last_part),
        .exhausted  (exhausted),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Result side. Handshakes are sampled straight after the rising edge,
    // before any nonblocking update of that step lands, so every signal
    // read here still holds its pre-edge value.
    // ------------------------------------------------------------------
    initial
    begin
        part_result_t seen;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                seen.value = part_value;
                seen.index = part_index;
                seen.last  = last_part;
                seen.exh   = exhausted;
                walk_board.check_part(seen);
            end
            // a long hold-off lets the output back up into the request port
            if (hold_off_left > 0)
            begin
                out_ready <= 1'b0;
                hold_off_left--;
            end
            else
            begin
                out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: any handshake on any channel counts as progress.
    // ------------------------------------------------------------------
    initial
    begin
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("weak_composition_enumerator verification failed");
        $finish;
    end

    task automatic set_mode(int mode);
        case (mode)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 69; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 69; end
            default: begin send_idle_pct = 37; recv_stall_pct = 37; end
        endcase
    endtask

    // Valid is only dropped on idle cycles, so back-to-back requests keep it
    // high across the acceptance edge.
    task automatic send_request(logic rewind);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        restart  <= rewind;
        @(posedge clk);
        while (!(in_valid && in_ready))
            @(posedge clk);
        walk_board.note_request(rewind);
        requests_sent++;
    endtask

    task automatic send_burst(int count, int restart_pct);
        for (int i = 0; i < count; i++)
            send_request($urandom_range(0, 99) < restart_pct);
        in_valid <= 1'b0;
        restart  <= 1'b0;
    endtask

    // waiting after the write keeps valid from toggling in one step
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!(cfg_valid && cfg_ready))
            @(posedge clk);
        walk_board.write_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // all parts returned, then a DRAIN_CYCLES wait before touching registers
    task automatic settle();
        while (walk_board.expected_parts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int                    phase;
        int                    count;
        logic [CFG_DATA_W-1:0] n_data;
        logic [CFG_DATA_W-1:0] d_data;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // -------------------- directed --------------------
        set_mode(0);

        // reset walk n=3, d=2: six vectors, then exhausted twice (state held),
        // then a restart request rewinds to the first vector
        send_burst(8, 0);
        settle();
        send_request(1'b1);
        send_burst(0, 0);
        settle();

        // spare indexes must neither change a register nor rewind
        write_reg(REG_SPARE_A, 8'hAA);
        write_reg(REG_SPARE_B, 8'h55);
        send_burst(1, 0);
        settle();

        // zero parts acts as a single part: one vector, then exhausted;
        // a restart after exhaustion brings the vector back
        write_reg(REG_NUM_PARTS, 8'hE0);
        write_reg(REG_TOTAL_SUM, 8'hFF);
        send_burst(2, 0);
        settle();
        send_request(1'b1);
        send_burst(0, 0);
        settle();

        // 31 parts saturates to the full sixteen
        write_reg(REG_NUM_PARTS, 8'hFF);
        write_reg(REG_TOTAL_SUM, 8'h01);
        send_burst(3, 0);
        settle();

        // zero sum over sixteen parts: a single all-zero vector
        write_reg(REG_NUM_PARTS, 8'h10);
        write_reg(REG_TOTAL_SUM, 8'h00);
        send_burst(2, 0);
        settle();

        // top of the sum range, then restart mid-walk
        write_reg(REG_NUM_PARTS, 8'h02);
        write_reg(REG_TOTAL_SUM, 8'hFF);
        send_burst(3, 0);
        settle();
        send_request(1'b1);
        send_burst(0, 0);
        settle();

        // a single register write rewinds, keeping the other register
        write_reg(REG_TOTAL_SUM, 8'h03);
        send_burst(2, 0);

        // -------------------- random --------------------
        phase = 0;
        while (requests_sent < TARGET_REQUESTS)
        begin
            settle();
            set_mode(phase % 4);
            if (phase == 2)
            begin
                // back-pressure: the receiver holds off while requests keep
                // coming, so the block fills and stalls its request port
                set_mode(0);
                write_reg(REG_NUM_PARTS, 8'h04);
                write_reg(REG_TOTAL_SUM, 8'h04);
                hold_off_left = HOLD_OFF_CYCLES;
                send_burst(24, 0);
            end
            else
            begin
                // mostly small walks that run to exhaustion, now and then
                // arbitrary register values with only a few requests
                if ($urandom_range(0, 7) == 0)
                begin
                    n_data = CFG_DATA_W'($urandom_range(0, 255));
                    d_data = CFG_DATA_W'($urandom_range(0, 255));
                    count  = $urandom_range(3, 8);
                end
                else
                begin
                    n_data = CFG_DATA_W'($urandom_range(1, 4));
                    d_data = CFG_DATA_W'($urandom_range(0, 4));
                    count  = $urandom_range(15, 45);
                end
                case ($urandom_range(0, 3))
                    0:
                    begin
                        write_reg(REG_NUM_PARTS, n_data);
                    end
                    1:
                    begin
                        write_reg(REG_TOTAL_SUM, d_data);
                    end
                    2:
                    begin
                        write_reg(REG_NUM_PARTS, n_data);
                        write_reg(REG_TOTAL_SUM, d_data);
                    end
                    default:
                    begin
                        write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                                  CFG_DATA_W'($urandom_range(0, 255)));
                        write_reg(REG_TOTAL_SUM, d_data);
                        write_reg(REG_NUM_PARTS, n_data);
                    end
                endcase
                send_burst(count, RESTART_PCT);
            end
            phase++;
        end

        settle();
        if (walk_board.mismatches == 0)
            $display("weak_composition_enumerator verification clean");
        else
            $display("weak_composition_enumerator verification failed");
        $finish;
    end

endmodule
